[hw/rtl/urh_pkg.sv]
// shared types and constants for the undo/redo history block
// no dependencies; every other file but urh_ram takes names from here by scope
package urh_pkg;

    localparam int HIST_DEPTH = 4096;
    localparam int ADDR_W     = $clog2(HIST_DEPTH);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int REC_W      = 64;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [REC_W-1:0]  rec_t;

    typedef enum logic [1:0] {
        FUNC_PUSH = 2'd0,
        FUNC_UNDO = 2'd1,
        FUNC_REDO = 2'd2
    } func_t;

    typedef struct packed {
        logic ok;
        rec_t edit_out;
        logic can_undo;
        logic can_redo;
    } result_t;

endpackage

[hw/rtl/urh_in_if.sv]
// command channel: operation code and edit record, valid/ready handshake
// depends on urh_pkg
interface urh_in_if;

    logic          valid;
    logic          ready;
    logic [1:0]    func;
    urh_pkg::rec_t edit_record;

    modport source (output valid, output func, output edit_record, input ready);
    modport sink   (input valid, input func, input edit_record, output ready);

endinterface

[hw/rtl/urh_out_if.sv]
// result channel: status, moved record and availability flags
// depends on urh_pkg
interface urh_out_if;

    logic          valid;
    logic          ready;
    logic          ok;
    urh_pkg::rec_t edit_out;
    logic          can_undo;
    logic          can_redo;

    modport source (output valid, output ok, output edit_out, output can_undo,
                    output can_redo, input ready);
    modport sink   (input valid, input ok, input edit_out, input can_undo,
                    input can_redo, output ready);

endinterface

[hw/rtl/undo_redo_history_stacks_top.sv]
// Undo/redo history: two rings of 4096 records of 64 bits, each held in a
// synchronous ram with a base pointer and a fill count in flip-flops. A push,
// an undo or redo on an empty stack and an unused code finish in ST_IDLE. A
// successful undo or redo reads the newest record of the source stack from
// its ram in ST_IDLE and writes it on top of the other stack in ST_MOVE; no
// new command is taken in between, so no access overlaps the write of the
// same entry. Results go through a two-beat buffer, so commands keep flowing
// while a result waits, unless the buffer is full. The rams are not cleared
// after reset; an entry is only ever read after it has been written.
module undo_redo_history_stacks_top (
    input  logic      clk,
    input  logic      rst_n,
    urh_in_if.sink    cmd,
    urh_out_if.source rsp
);

    typedef enum logic {
        ST_IDLE,
        ST_MOVE
    } state_t;

    typedef struct packed {
        urh_pkg::addr_t base;
        urh_pkg::cnt_t  count;
    } ring_t;

    localparam urh_pkg::cnt_t DEPTH_CNT = urh_pkg::CNT_W'(urh_pkg::HIST_DEPTH);

    function automatic ring_t ring_push(ring_t r);
        ring_t n;
        n = r;
        if (r.count < DEPTH_CNT)
        begin
            n.count = r.count + urh_pkg::CNT_W'(1);
        end
        else
        begin
            n.base = r.base + urh_pkg::ADDR_W'(1);
        end
        return n;
    endfunction

    state_t           state_reg;
    state_t           state_next;
    logic             from_undo_reg;
    logic             from_undo_next;
    ring_t            undo_ring_reg;
    ring_t            undo_ring_next;
    ring_t            redo_ring_reg;
    ring_t            redo_ring_next;

    logic             acc;
    logic             fifo_full;
    logic             res_valid;
    urh_pkg::result_t res;

    urh_pkg::addr_t   undo_push_addr;
    urh_pkg::addr_t   undo_top_addr;
    urh_pkg::addr_t   redo_push_addr;
    urh_pkg::addr_t   redo_top_addr;

    logic             undo_we;
    urh_pkg::rec_t    undo_wdata;
    logic             undo_re;
    urh_pkg::rec_t    undo_rdata;
    logic             redo_we;
    urh_pkg::rec_t    redo_wdata;
    logic             redo_re;
    urh_pkg::rec_t    redo_rdata;

    assign cmd.ready = (state_reg == ST_IDLE) && !fifo_full;
    assign acc       = cmd.valid && cmd.ready;

    // a full ring has count low bits zero, so base+count lands on the oldest entry
    assign undo_push_addr = undo_ring_reg.base + undo_ring_reg.count[urh_pkg::ADDR_W-1:0];
    assign redo_push_addr = redo_ring_reg.base + redo_ring_reg.count[urh_pkg::ADDR_W-1:0];
    assign undo_top_addr  = undo_push_addr - urh_pkg::ADDR_W'(1);
    assign redo_top_addr  = redo_push_addr - urh_pkg::ADDR_W'(1);

    always_comb
    begin
        state_next     = state_reg;
        from_undo_next = from_undo_reg;
        undo_ring_next = undo_ring_reg;
        redo_ring_next = redo_ring_reg;
        undo_we        = 1'b0;
        undo_wdata     = cmd.edit_record;
        undo_re        = 1'b0;
        redo_we        = 1'b0;
        redo_wdata     = undo_rdata;
        redo_re        = 1'b0;
        res_valid      = 1'b0;
        res.ok         = 1'b0;
        res.edit_out   = '0;
        res.can_undo   = (undo_ring_reg.count != '0);
        res.can_redo   = (redo_ring_reg.count != '0);

        case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    case (cmd.func)
                        urh_pkg::FUNC_PUSH:
                        begin
                            undo_we              = 1'b1;
                            undo_ring_next       = ring_push(undo_ring_reg);
                            redo_ring_next.count = '0;
                            res_valid            = 1'b1;
                            res.ok               = 1'b1;
                            res.can_undo         = 1'b1;
                            res.can_redo         = 1'b0;
                        end
                        urh_pkg::FUNC_UNDO:
                        begin
                            if (undo_ring_reg.count != '0)
                            begin
                                undo_re              = 1'b1;
                                undo_ring_next.count = undo_ring_reg.count - urh_pkg::CNT_W'(1);
                                from_undo_next       = 1'b1;
                                state_next           = ST_MOVE;
                            end
                            else
                            begin
                                res_valid = 1'b1;
                            end
                        end
                        urh_pkg::FUNC_REDO:
                        begin
                            if (redo_ring_reg.count != '0)
                            begin
                                redo_re              = 1'b1;
                                redo_ring_next.count = redo_ring_reg.count - urh_pkg::CNT_W'(1);
                                from_undo_next       = 1'b0;
                                state_next           = ST_MOVE;
                            end
                            else
                            begin
                                res_valid = 1'b1;
                            end
                        end
                        default:
                        begin
                            res_valid = 1'b1;
                        end
                    endcase
                end
            end
            ST_MOVE:
            begin
                // record read last cycle goes on top of the other stack
                res_valid  = 1'b1;
                res.ok     = 1'b1;
                state_next = ST_IDLE;
                if (from_undo_reg)
                begin
                    redo_we        = 1'b1;
                    redo_wdata     = undo_rdata;
                    redo_ring_next = ring_push(redo_ring_reg);
                    res.edit_out   = undo_rdata;
                    res.can_redo   = 1'b1;
                end
                else
                begin
                    undo_we        = 1'b1;
                    undo_wdata     = redo_rdata;
                    undo_ring_next = ring_push(undo_ring_reg);
                    res.edit_out   = redo_rdata;
                    res.can_undo   = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            from_undo_reg <= 1'b0;
            undo_ring_reg <= '0;
            redo_ring_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            from_undo_reg <= from_undo_next;
            undo_ring_reg <= undo_ring_next;
            redo_ring_reg <= redo_ring_next;
        end
    end

    urh_ram #(
        .DEPTH (urh_pkg::HIST_DEPTH),
        .WIDTH (urh_pkg::REC_W)
    ) u_undo_ram (
        .clk   (clk),
        .we    (undo_we),
        .waddr (undo_push_addr),
        .wdata (undo_wdata),
        .re    (undo_re),
        .raddr (undo_top_addr),
        .rdata (undo_rdata)
    );

    urh_ram #(
        .DEPTH (urh_pkg::HIST_DEPTH),
        .WIDTH (urh_pkg::REC_W)
    ) u_redo_ram (
        .clk   (clk),
        .we    (redo_we),
        .waddr (redo_push_addr),
        .wdata (redo_wdata),
        .re    (redo_re),
        .raddr (redo_top_addr),
        .rdata (redo_rdata)
    );

    urh_out_fifo u_out_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (res_valid),
        .wr_data  (res),
        .full     (fifo_full),
        .rsp      (rsp)
    );

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        undo_ring_reg.count <= DEPTH_CNT && redo_ring_reg.count <= DEPTH_CNT)
        else $error("history count beyond depth");

    a_move_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MOVE |-> $past(acc))
        else $error("move phase without an accepted command");

    a_move_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MOVE |=> state_reg == ST_IDLE)
        else $error("move phase longer than one cycle");

    a_push_clears_redo: assert property (@(posedge clk) disable iff (!rst_n)
        acc && cmd.func == urh_pkg::FUNC_PUSH |=>
            redo_ring_reg.count == '0 && undo_ring_reg.count != '0)
        else $error("push left redo history or empty undo history");

    a_no_result_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !fifo_full || (rsp.valid && rsp.ready))
        else $error("result written into a full buffer");
`endif

endmodule

[hw/rtl/urh_ram.sv]
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
module urh_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/urh_out_fifo.sv]
// two-beat result buffer in front of the result channel
// depends on urh_pkg and urh_out_if
module urh_out_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_valid,
    input  urh_pkg::result_t wr_data,
    output logic             full,
    urh_out_if.source        rsp
);

    urh_pkg::result_t slot_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       cnt_reg;
    logic [1:0]       cnt_next;
    logic             pop;
    urh_pkg::result_t head;

    assign pop  = rsp.valid && rsp.ready;
    assign full = (cnt_reg == 2'd2);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_valid)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (pop)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        case ({wr_valid, pop})
            2'b10:   cnt_next = cnt_reg + 2'd1;
            2'b01:   cnt_next = cnt_reg - 2'd1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_valid)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign head         = slot_reg[rd_ptr_reg];
    assign rsp.valid    = (cnt_reg != 2'd0);
    assign rsp.ok       = head.ok;
    assign rsp.edit_out = head.edit_out;
    assign rsp.can_undo = head.can_undo;
    assign rsp.can_redo = head.can_redo;

endmodule
